// ===== src/ptps_pkg.sv =====
// Shared types and constants of the peak-to-peak Schmitt onset detector.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ptps_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int VOLUME_W  = 16;
    localparam int THRESH_W  = 16;
    localparam int CFG_IDX_W = 8;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [VOLUME_W-1:0] t_volume;
    typedef logic        [THRESH_W-1:0] t_thresh;
    typedef logic        [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes.
    localparam t_cfg_idx REG_UPPER = 8'd0;
    localparam t_cfg_idx REG_LOWER = 8'd1;

    localparam t_thresh UPPER_RESET = 16'd1200;
    localparam t_thresh LOWER_RESET = 16'd500;

    // Running extremes start at the opposite ends of the sample range.
    localparam t_sample MAX_RESET = 16'sh8000;
    localparam t_sample MIN_RESET = 16'sh7FFF;

    typedef struct packed {
        logic onset;
        logic level;
    } t_trig;

endpackage

`default_nettype wire

// ===== src/ptps_if.sv =====
// Valid/ready channel interfaces for sample items and result items.
// Depends on ptps_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface ptps_sample_if;
    import ptps_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;
    logic    last_of_block;

    modport source (output valid, output sample, output last_of_block, input ready);
    modport sink   (input valid, input sample, input last_of_block, output ready);
endinterface

interface ptps_result_if;
    import ptps_pkg::*;

    logic    valid;
    logic    ready;
    logic    onset;
    t_volume volume;
    logic    trigger_level;

    modport source (output valid, output onset, output volume, output trigger_level,
                    input ready);
    modport sink   (input valid, input onset, input volume, input trigger_level,
                    output ready);
endinterface

`default_nettype wire

// ===== src/peak_to_peak_schmitt_onset_top.sv =====
// Top level of the peak-to-peak Schmitt onset detector.
// Depends on ptps_pkg, ptps_if, ptps_tracker and ptps_trigger.
//
// Usage: signed 16-bit samples arrive on i_smp, a valid/ready channel; the
// last sample of each block carries last_of_block. One result item per block
// (onset, volume, trigger_level) leaves on o_res; other samples give none.
// Thresholds are written through i_cfg_we / i_cfg_idx / i_cfg_wdata: index 0
// is the upper threshold, index 1 the lower one, other indexes are ignored.
// An item is registered in the input register at acceptance and processed
// from there; a block result is registered when its last sample is processed.
// Throughput is one sample per cycle while no block-end sample waits, set by
// the single register-to-register pass via the max/min and threshold compares.
// Synchronous reset (i_rst_n low) empties both registers, clears the trigger,
// restarts block tracking and loads thresholds 1200 and 500.
// When the receiver stalls, the result is held; samples that end no block
// still flow, and a block-end sample waits in the input register.
`timescale 1ns / 1ps
`default_nettype none

module peak_to_peak_schmitt_onset_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire ptps_pkg::t_cfg_idx i_cfg_idx,
    input  wire ptps_pkg::t_thresh  i_cfg_wdata,
    ptps_sample_if.sink             i_smp,
    ptps_result_if.source           o_res
);
    import ptps_pkg::*;

    logic    r_in_valid;
    t_sample r_in_sample;
    logic    r_in_last;

    logic    r_out_valid;
    logic    r_out_onset;
    t_volume r_out_volume;
    logic    r_out_level;

    logic    out_free;
    logic    take;
    t_volume volume;
    t_trig   trig;

    assign out_free    = !r_out_valid || o_res.ready;
    // A sample that ends no block needs no room in the result register.
    assign take        = r_in_valid && (!r_in_last || out_free);
    assign i_smp.ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_smp.ready) begin
            r_in_valid <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_smp.ready && i_smp.valid) begin
            r_in_sample <= i_smp.sample;
            r_in_last   <= i_smp.last_of_block;
        end
    end

    ptps_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_sample (r_in_sample),
        .i_last   (r_in_last),
        .o_volume (volume)
    );

    ptps_trigger u_trigger (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (take && r_in_last),
        .i_volume    (volume),
        .o_trig      (trig)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= take && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_in_last) begin
            r_out_onset  <= trig.onset;
            r_out_volume <= volume;
            r_out_level  <= trig.level;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.onset         = r_out_onset;
    assign o_res.volume        = r_out_volume;
    assign o_res.trigger_level = r_out_level;

endmodule

`default_nettype wire

// ===== src/ptps_tracker.sv =====
// Running maximum and minimum of the current block and its peak-to-peak volume.
// Depends on ptps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptps_tracker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire ptps_pkg::t_sample i_sample,
    input  wire logic              i_last,
    output ptps_pkg::t_volume      o_volume
);
    import ptps_pkg::*;

    t_sample r_max;
    t_sample r_min;
    t_sample n_max;
    t_sample n_min;

    always_comb begin
        n_max    = (i_sample > r_max) ? i_sample : r_max;
        n_min    = (i_sample < r_min) ? i_sample : r_min;
        // Difference wraps modulo 2^16, which covers the full signed span.
        o_volume = t_volume'(n_max) - t_volume'(n_min);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_RESET;
            r_min <= MIN_RESET;
        end else if (i_take) begin
            if (i_last) begin
                r_max <= MAX_RESET;
                r_min <= MIN_RESET;
            end else begin
                r_max <= n_max;
                r_min <= n_min;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/ptps_trigger.sv =====
// Schmitt trigger on the block volume, with its threshold registers.
// Depends on ptps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptps_trigger (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire ptps_pkg::t_cfg_idx i_cfg_idx,
    input  wire ptps_pkg::t_thresh  i_cfg_wdata,
    input  wire logic               i_take,
    input  wire ptps_pkg::t_volume  i_volume,
    output ptps_pkg::t_trig         o_trig
);
    import ptps_pkg::*;

    t_thresh r_upper;
    t_thresh r_lower;
    logic    r_set;

    always_comb begin
        o_trig.onset = 1'b0;
        o_trig.level = r_set;
        // The upper test wins when the thresholds are crossed over.
        if (i_volume > r_upper) begin
            o_trig.level = 1'b1;
            o_trig.onset = !r_set;
        end else if (i_volume < r_lower) begin
            o_trig.level = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper <= UPPER_RESET;
            r_lower <= LOWER_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_UPPER: r_upper <= i_cfg_wdata;
                REG_LOWER: r_lower <= i_cfg_wdata;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set <= 1'b0;
        end else if (i_take) begin
            r_set <= o_trig.level;
        end
    end

endmodule

`default_nettype wire
